>>> hw/rtl/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared constants, types and controller/datapath signal groups for the
// boost converter duty controller.
// ----------------------------------------------------------------------------
package pbd_pkg;

    // adc width and full scale code
    localparam int ADC_BITS = 10;
    localparam logic [ADC_BITS-1:0] ADC_FS = {ADC_BITS{1'b1}};
    localparam int IN_TDATA_W = ((ADC_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 16;

    // volts scale: 3.3 / 0.176 * 65536, result in q5.16
    localparam int VSCALE = 1228800;
    localparam int VW = 21;
    localparam int XW = ADC_BITS + VW;
    localparam logic [XW-1:0] HALF_FS = XW'(ADC_FS >> 1);

    localparam int ERR_W = 24;
    localparam int SUM_W = 40;
    localparam int DER_W = ERR_W + 1;
    localparam int GAIN_W = 16;
    localparam int OPB_W = 25;
    localparam int PROD_W = GAIN_W + 1 + OPB_W;
    localparam int ACC_W = 58;

    localparam logic signed [ERR_W-1:0] SETTLE_BAND = 24'sd3276;

    // configuration register map
    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_GAIN_P = 3'd1;
    localparam logic [2:0] REG_GAIN_I = 3'd2;
    localparam logic [2:0] REG_GAIN_D = 3'd3;
    localparam logic [2:0] REG_DUTY_CAP = 3'd4;

    // multiplier operand selection
    localparam logic [1:0] MAC_P = 2'd0;
    localparam logic [1:0] MAC_D = 2'd1;
    localparam logic [1:0] MAC_I_LO = 2'd2;
    localparam logic [1:0] MAC_I_HI = 2'd3;

    typedef struct packed {
        logic [3:0] target_volts;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [7:0] duty_cap;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic scale;
        logic div_step;
        logic err;
        logic mac_issue;
        logic [1:0] mac_sel;
        logic mac_clear;
        logic mac_acc;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

endpackage

>>> hw/rtl/pbd_regs.sv
// ----------------------------------------------------------------------------
// pbd_regs
// Configuration register bank behind an apb-style port.
// ----------------------------------------------------------------------------
module pbd_regs import pbd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[CFG_AW-1:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_TARGET:   cfg_next.target_volts = pwdata[3:0];
                REG_GAIN_P:   cfg_next.gain_p = pwdata[GAIN_W-1:0];
                REG_GAIN_I:   cfg_next.gain_i = pwdata[GAIN_W-1:0];
                REG_GAIN_D:   cfg_next.gain_d = pwdata[GAIN_W-1:0];
                REG_DUTY_CAP: cfg_next.duty_cap = pwdata[7:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TARGET:   prdata = {28'd0, cfg_reg.target_volts};
            REG_GAIN_P:   prdata = {16'd0, cfg_reg.gain_p};
            REG_GAIN_I:   prdata = {16'd0, cfg_reg.gain_i};
            REG_GAIN_D:   prdata = {16'd0, cfg_reg.gain_d};
            REG_DUTY_CAP: prdata = {24'd0, cfg_reg.duty_cap};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_volts <= 4'd2;
            cfg_reg.gain_p       <= 16'd1408;
            cfg_reg.gain_i       <= 16'd307;
            cfg_reg.gain_d       <= 16'd256;
            cfg_reg.duty_cap     <= 8'd240;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/pbd_datapath.sv
// ----------------------------------------------------------------------------
// pbd_datapath
// Sample scaling, error and integral state, shared gain multiplier with
// accumulator, and the duty clamp feeding the result register.
// ----------------------------------------------------------------------------
module pbd_datapath import pbd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [ADC_BITS-1:0] adc_sample,
    input  cfg_t                cfg,
    input  cmd_t                cmd,
    output stat_t               stat,
    output logic [7:0]          duty,
    output logic                settled
);

    logic [ADC_BITS-1:0] code_reg;
    logic [XW-1:0] x_reg;
    logic [VW-1:0] q_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [ERR_W-1:0] prev_reg;
    logic signed [DER_W-1:0] deriv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic prod_hi_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [7:0] duty_reg;
    logic settled_reg;
    logic err_settled_reg;

    logic [VW-1:0] x_hi;
    logic [ADC_BITS-1:0] x_lo;
    logic [XW-1:0] scaled;
    logic [VW-1:0] volts;
    logic signed [ERR_W-1:0] err_c;
    logic signed [SUM_W:0] sum_wide;
    logic signed [GAIN_W:0] mul_a;
    logic signed [OPB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [ACC_W-1:0] addend;
    logic [7:0] duty_raw;
    logic [7:0] duty_c;

    // divide by 2^n-1: x = a*2^n + b gives a*(2^n-1) + (a+b)
    assign x_hi = x_reg[XW-1:ADC_BITS];
    assign x_lo = x_reg[ADC_BITS-1:0];
    assign stat.div_done = (x_hi == '0);
    assign scaled = XW'({{(XW-ADC_BITS){1'b0}}, code_reg} * XW'(VSCALE)) + HALF_FS;
    assign volts = q_reg + VW'(x_lo == ADC_FS);

    assign err_c = $signed({4'd0, cfg.target_volts, 16'd0}) - $signed({3'd0, volts});
    assign sum_wide = {sum_reg[SUM_W-1], sum_reg} + {{(SUM_W-ERR_W+1){err_c[ERR_W-1]}}, err_c};

    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    always_comb begin
        unique case (cmd.mac_sel)
            MAC_P: begin
                mul_a = $signed({1'b0, cfg.gain_p});
                mul_b = {err_reg[ERR_W-1], err_reg};
            end
            MAC_D: begin
                mul_a = $signed({1'b0, cfg.gain_d});
                mul_b = deriv_reg;
            end
            MAC_I_LO: begin
                mul_a = $signed({1'b0, cfg.gain_i});
                mul_b = $signed({5'd0, sum_reg[19:0]});
            end
            MAC_I_HI: begin
                mul_a = $signed({1'b0, cfg.gain_i});
                mul_b = {{5{sum_reg[SUM_W-1]}}, sum_reg[SUM_W-1:20]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;
    // upper half of the integral term weighs 2^20
    assign addend = prod_hi_reg ? {prod_reg[ACC_W-21:0], 20'd0}
                                : {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb begin
        priority if (acc_reg[ACC_W-1]) begin
            duty_raw = 8'd0;
        end else if (acc_reg[ACC_W-1:32] != '0) begin
            duty_raw = 8'd255;
        end else begin
            duty_raw = acc_reg[31:24];
        end
        duty_c = (duty_raw > cfg.duty_cap) ? cfg.duty_cap : duty_raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end else if (cmd.err) begin
            sum_reg  <= sum_next;
            prev_reg <= err_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            code_reg <= adc_sample;
        end
        if (cmd.scale) begin
            x_reg <= scaled;
            q_reg <= '0;
        end else if (cmd.div_step) begin
            x_reg <= XW'(x_hi) + XW'(x_lo);
            q_reg <= q_reg + x_hi;
        end
        if (cmd.err) begin
            err_reg         <= err_c;
            deriv_reg       <= {err_c[ERR_W-1], err_c} - {prev_reg[ERR_W-1], prev_reg};
            err_settled_reg <= (err_c <= SETTLE_BAND) && (err_c >= -SETTLE_BAND);
        end
        if (cmd.mac_issue) begin
            prod_reg    <= prod_c;
            prod_hi_reg <= (cmd.mac_sel == MAC_I_HI);
        end
        if (cmd.mac_clear) begin
            acc_reg <= '0;
        end else if (cmd.mac_acc) begin
            acc_reg <= acc_reg + addend;
        end
        if (cmd.load_out) begin
            duty_reg    <= duty_c;
            settled_reg <= err_settled_reg;
        end
    end

    assign duty    = duty_reg;
    assign settled = settled_reg;

endmodule

>>> hw/rtl/pbd_ctrl.sv
// ----------------------------------------------------------------------------
// pbd_ctrl
// Sequencer for one item: scale, divide loop, error update, four multiply
// passes and the handover to the result register.
// ----------------------------------------------------------------------------
module pbd_ctrl import pbd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_ERR   = 3'd3;
    localparam logic [2:0] ST_MAC   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_ERR;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_ERR: begin
                cmd.err    = 1'b1;
                cnt_next   = 3'd0;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                // issue on counts 0..3, accumulate the previous product on 1..4
                cmd.mac_sel   = cnt_reg[1:0];
                cmd.mac_issue = !cnt_reg[2];
                cmd.mac_clear = (cnt_reg == 3'd0);
                cmd.mac_acc   = (cnt_reg != 3'd0);
                cnt_next      = cnt_reg + 3'd1;
                if (cnt_reg[2]) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        priority if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/pid_boost_duty_controller.sv
// the time from input acceptance to result valid is set by the
// divide-by-full-scale loop and the passes of the shared gain multiplier
// with its accumulator; no new item is taken until the last result is loaded.
// a finished result waits in the output register while the next item runs.
// reset (aresetn low, synchronous) clears the integral and previous error,
// the sequencer and the result valid, and loads the register defaults.
// ----------------------------------------------------------------------------
// pid_boost_duty_controller
// PID duty controller for a boost converter: adc sample in, pwm duty and
// settled flag out, gains and target set through an apb-style port.
// ----------------------------------------------------------------------------
module pid_boost_duty_controller import pbd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] adc_sample, rest zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] duty, [8] settled, rest zero
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_AW-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cfg_t cfg;
    cmd_t cmd;
    stat_t stat;
    logic [7:0] duty;
    logic settled;

    pbd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pbd_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adc_sample (s_tdata[ADC_BITS-1:0]),
        .cfg        (cfg),
        .cmd        (cmd),
        .stat       (stat),
        .duty       (duty),
        .settled    (settled)
    );

    assign m_tdata = {{(OUT_TDATA_W-9){1'b0}}, settled, duty};

endmodule

>>> bench/pbd_checker.sv
// ----------------------------------------------------------------------------
// pbd_checker
// Watches the sample, result and register ports of the duty controller,
// predicts duty and settled flag for each accepted sample and compares them
// with the results in order.
// ----------------------------------------------------------------------------
module pbd_checker import pbd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] adc_sample, rest zero
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] duty, [8] settled, rest zero
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_AW-1:0]      paddr,
    input  logic [31:0]            pwdata,
    input  logic                   pready,
    input  logic                   flush_check,
    output int                     failures,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] duty;
        logic       settled;
    } duty_word_t;

    localparam longint INTEGRAL_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint INTEGRAL_LO = -(longint'(1) <<< (SUM_W - 1));

    cfg_t       cfg;
    longint     integral;
    longint     prev_err;
    duty_word_t duty_due[$];
    int         mismatch_count = 0;
    int         pending_n = 0;
    int         result_idx = 0;
    bit         flushed = 1'b0;

    assign failures = mismatch_count;
    assign outstanding = pending_n;

    task automatic flag_error(input string msg);
        if (mismatch_count < 100)
            $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // one control tick: volts, error, saturating integral, gain sum, clamps
    function automatic duty_word_t advance_loop(input logic [ADC_BITS-1:0] code);
        longint     fs;
        longint     volts;
        longint     err;
        longint     deriv;
        longint     acc;
        longint     raw;
        duty_word_t w;
        fs = longint'(ADC_FS);
        volts = (longint'(code) * VSCALE + fs / 2) / fs;
        err = longint'(cfg.target_volts) * 65536 - volts;
        integral += err;
        if (integral > INTEGRAL_HI) integral = INTEGRAL_HI;
        if (integral < INTEGRAL_LO) integral = INTEGRAL_LO;
        deriv = err - prev_err;
        acc = longint'(cfg.gain_p) * err + longint'(cfg.gain_i) * integral
            + longint'(cfg.gain_d) * deriv;
        if (acc < 0) begin
            raw = 0;
        end else begin
            raw = acc >>> 24;
            if (raw > 255) raw = 255;
        end
        if (raw > longint'(cfg.duty_cap)) raw = longint'(cfg.duty_cap);
        w.duty = raw[7:0];
        w.settled = (err <= longint'(SETTLE_BAND)) && (err >= -longint'(SETTLE_BAND));
        prev_err = err;
        return w;
    endfunction

    always @(posedge aclk) begin : watch
        duty_word_t want;
        duty_word_t got;
        if (!aresetn) begin
            cfg.target_volts = 4'd2;
            cfg.gain_p = 16'd1408;
            cfg.gain_i = 16'd307;
            cfg.gain_d = 16'd256;
            cfg.duty_cap = 8'd240;
            integral = 0;
            prev_err = 0;
            duty_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_AW-1:2])
                    REG_TARGET:   cfg.target_volts = pwdata[3:0];
                    REG_GAIN_P:   cfg.gain_p = pwdata[GAIN_W-1:0];
                    REG_GAIN_I:   cfg.gain_i = pwdata[GAIN_W-1:0];
                    REG_GAIN_D:   cfg.gain_d = pwdata[GAIN_W-1:0];
                    REG_DUTY_CAP: cfg.duty_cap = pwdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                duty_due.push_back(advance_loop(s_tdata[ADC_BITS-1:0]));
            if (m_tvalid && m_tready) begin
                got.duty = m_tdata[7:0];
                got.settled = m_tdata[8];
                if (duty_due.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with no sample pending",
                                         result_idx));
                end else begin
                    want = duty_due.pop_front();
                    if (got.duty !== want.duty)
                        flag_error($sformatf("result %0d duty %0d, predicted %0d",
                                             result_idx, got.duty, want.duty));
                    if (got.settled !== want.settled)
                        flag_error($sformatf("result %0d settled %0b, predicted %0b",
                                             result_idx, got.settled, want.settled));
                end
                result_idx++;
            end
            if (flush_check && !flushed) begin
                flushed = 1'b1;
                if (duty_due.size() != 0)
                    flag_error($sformatf("%0d results never arrived", duty_due.size()));
            end
        end
        pending_n <= duty_due.size();
    end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives adc samples and register settings into the duty controller under
// several stall patterns; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb_top import pbd_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    localparam int NUM_REGS = 5;
    localparam int NUM_PHASES = 12;
    localparam logic [ADC_BITS-1:0] EDGE_SAMPLES [13] = '{
        10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd1022,
        10'd106, 10'd107, 10'd108, 10'd109, 10'd110, 10'd111, 10'd112
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [9:0] adc_sample, rest zero
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [7:0] duty, [8] settled, rest zero
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_AW-1:0]      paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   flush_check = 1'b0;
    int                     failures;
    int                     outstanding;

    int                     send_gap_pct = 0;
    int                     recv_stall_pct = 0;
    logic [3:0]             cur_target = 4'd2;

    always #1 aclk = ~aclk;

    pid_boost_duty_controller u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pbd_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .flush_check(flush_check),
        .failures(failures), .outstanding(outstanding)
    );

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_gap_pct = 60; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 60; end
            IDLE_BOTH:     begin send_gap_pct = 17; recv_stall_pct = 17; end
        endcase
    endtask

    // valid stays high after acceptance; the next call raises it again or idles
    task automatic send_sample(input logic [ADC_BITS-1:0] code);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'(code);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // upper bits of the write data carry noise that the block must drop
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value,
                             input int width);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value | ($urandom << width);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [3:0] tgt, input logic [15:0] gp,
                             input logic [15:0] gi, input logic [15:0] gd,
                             input logic [7:0] cap);
        write_reg(REG_TARGET, 32'(tgt), 4);
        write_reg(REG_GAIN_P, 32'(gp), GAIN_W);
        write_reg(REG_GAIN_I, 32'(gi), GAIN_W);
        write_reg(REG_GAIN_D, 32'(gd), GAIN_W);
        write_reg(REG_DUTY_CAP, 32'(cap), 8);
        write_reg(3'(NUM_REGS + $urandom_range(2)), $urandom, 32);
        psel <= 1'b0;
        penable <= 1'b0;
        cur_target = tgt;
    endtask

    function automatic logic [15:0] pick_gain();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($urandom_range(2047));
    endfunction

    // mostly samples near the target code so the loop stays in its working range
    function automatic logic [ADC_BITS-1:0] pick_sample();
        int centre;
        int v;
        if ($urandom_range(3) == 0) return ADC_BITS'($urandom_range(1023));
        centre = int'(cur_target) * 1023 * 65536 / VSCALE;
        v = centre + int'($urandom_range(80)) - 40;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return ADC_BITS'(v);
    endfunction

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idle(IDLE_NONE);
        foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i]);

        for (int p = 1; p < NUM_PHASES; p++) begin
            drain();
            set_idle(idle_mode_e'(p % 4));
            case (p)
                1: begin
                    configure(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
                    repeat (6) send_sample(10'd0);
                end
                2: begin
                    // drives the integral from positive after the previous phase to negative
                    configure(4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
                    repeat (5) send_sample(10'd1023);
                    send_sample(10'd0);
                end
                3: begin
                    configure(4'd1, 16'd0, 16'd0, 16'd0, 8'd255);
                    repeat (40) send_sample(pick_sample());
                end
                4: begin
                    configure(4'd11, 16'd8192, 16'd0, 16'd0, 8'd100);
                    repeat (40) send_sample(pick_sample());
                end
                default: begin
                    configure(4'($urandom_range(15)), pick_gain(), pick_gain(), pick_gain(),
                              ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(255)));
                    repeat (100) send_sample(pick_sample());
                end
            endcase
        end

        drain();
        repeat (20) @(posedge aclk);
        flush_check <= 1'b1;
        repeat (2) @(posedge aclk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #1ms;
        $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pbd_pkg.sv
hw/rtl/pbd_regs.sv
hw/rtl/pbd_datapath.sv
hw/rtl/pbd_ctrl.sv
hw/rtl/pid_boost_duty_controller.sv
bench/pbd_checker.sv
bench/tb_top.sv
